// File: rtl/tlt_pkg.sv
// ============================================================================
// tlt_pkg - shared types and codes for the time stamp list table
// Request and status codes, the packed stamp, the controller command and the
// datapath status groups.
// ============================================================================
`default_nettype none

package tlt_pkg;

   localparam int OP_W     = 3;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int WR_W     = 3;

   // request codes
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
   localparam logic [OP_W-1:0] OP_REWIND    = 3'd4;
   localparam logic [OP_W-1:0] OP_READ      = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EOL     = 2'd3;

   // table write source select
   localparam logic [WR_W-1:0] WR_NONE  = 3'd0;
   localparam logic [WR_W-1:0] WR_UP    = 3'd1;
   localparam logic [WR_W-1:0] WR_DOWN  = 3'd2;
   localparam logic [WR_W-1:0] WR_FRONT = 3'd3;
   localparam logic [WR_W-1:0] WR_END   = 3'd4;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } stamp_type;

   typedef struct packed {
      logic                capture;
      logic                mem_rd;
      logic                rd_cursor;
      logic                idx_last_ld;
      logic                idx_zero_ld;
      logic                idx_next_ld;
      logic                idx_inc;
      logic                idx_dec;
      logic [WR_W-1:0]     wr_sel;
      logic                count_inc;
      logic                count_dec;
      logic                count_clr;
      logic                cursor_inc;
      logic                cursor_clr;
      logic                cursor_front;
      logic                cursor_del;
      logic                found_set;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            cursor_lt_count;
      logic            rvalid;
      logic            hit;
      logic            prev_last;
      logic            idx_last;
      logic            idx_zero;
      logic            out_free;
   } dp_status_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      stamp_type           stamp;
      logic [COUNT_W-1:0]  count;
      logic                full;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/tlt_if.sv
// ============================================================================
// tlt_if - request and response channel interfaces
// Valid/ready channels carrying the table request and the table result.
// ============================================================================
`default_nettype none

interface tlt_req_if;
   import tlt_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   req_type;
   logic [HOUR_W-1:0] hour;
   logic [MIN_W-1:0]  minute;
   logic [SEC_W-1:0]  second;

   modport source (output valid, output req_type, output hour, output minute,
                   output second, input ready);
   modport sink   (input valid, input req_type, input hour, input minute,
                   input second, output ready);
endinterface

interface tlt_rsp_if;
   import tlt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [HOUR_W-1:0]   out_hour;
   logic [MIN_W-1:0]    out_minute;
   logic [SEC_W-1:0]    out_second;
   logic [COUNT_W-1:0]  entry_count;
   logic                table_full;

   modport source (output valid, output status, output found, output out_hour,
                   output out_minute, output out_second, output entry_count,
                   output table_full, input ready);
   modport sink   (input valid, input status, input found, input out_hour,
                   input out_minute, input out_second, input entry_count,
                   input table_full, output ready);
endinterface

`default_nettype wire

// File: rtl/tlt_ctrl.sv
// ============================================================================
// tlt_ctrl - request sequencer
// Decodes a captured request and steps the datapath through table walks:
// shift up for front insert, scan for delete and find, shift down after a
// delete hit, then hands the result to the output register.
// ============================================================================
`default_nettype none

module tlt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output tlt_pkg::ctrl_cmd_type  cmd,
   input  tlt_pkg::dp_status_type st
);
   import tlt_pkg::*;

   localparam int SW = 4;
   localparam logic [SW-1:0] S_IDLE      = 4'd0;
   localparam logic [SW-1:0] S_DECODE    = 4'd1;
   localparam logic [SW-1:0] S_UP        = 4'd2;
   localparam logic [SW-1:0] S_UP_TAIL   = 4'd3;
   localparam logic [SW-1:0] S_WR_FRONT  = 4'd4;
   localparam logic [SW-1:0] S_SCAN      = 4'd5;
   localparam logic [SW-1:0] S_DOWN      = 4'd6;
   localparam logic [SW-1:0] S_DOWN_TAIL = 4'd7;
   localparam logic [SW-1:0] S_DEL_DONE  = 4'd8;
   localparam logic [SW-1:0] S_FINISH    = 4'd9;

   logic [SW-1:0]       state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (st.op)
               OP_INS_FRONT: begin
                  if (st.full) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else if (st.empty) begin
                     cmd.wr_sel       = WR_FRONT;
                     cmd.count_inc    = 1'b1;
                     cmd.cursor_front = 1'b1;
                     status_in        = ST_OK;
                     state_in         = S_FINISH;
                  end else begin
                     cmd.idx_last_ld = 1'b1;
                     state_in        = S_UP;
                  end
               end
               OP_INS_END: begin
                  if (st.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.wr_sel    = WR_END;
                     cmd.count_inc = 1'b1;
                     status_in     = ST_OK;
                  end
                  state_in = S_FINISH;
               end
               OP_DELETE: begin
                  if (st.empty) begin
                     status_in = ST_NOMATCH;
                     state_in  = S_FINISH;
                  end else begin
                     cmd.idx_zero_ld = 1'b1;
                     state_in        = S_SCAN;
                  end
               end
               OP_FIND: begin
                  if (st.empty) begin
                     status_in = ST_OK;
                     state_in  = S_FINISH;
                  end else begin
                     cmd.idx_zero_ld = 1'b1;
                     state_in        = S_SCAN;
                  end
               end
               OP_REWIND: begin
                  cmd.cursor_clr = 1'b1;
                  status_in      = ST_OK;
                  state_in       = S_FINISH;
               end
               OP_READ: begin
                  if (st.cursor_lt_count) begin
                     cmd.mem_rd     = 1'b1;
                     cmd.rd_cursor  = 1'b1;
                     cmd.cursor_inc = 1'b1;
                     status_in      = ST_OK;
                  end else begin
                     status_in = ST_EOL;
                  end
                  state_in = S_FINISH;
               end
               OP_CLEAR: begin
                  cmd.count_clr  = 1'b1;
                  cmd.cursor_clr = 1'b1;
                  status_in      = ST_OK;
                  state_in       = S_FINISH;
               end
               default: begin
                  status_in = ST_OK;
                  state_in  = S_FINISH;
               end
            endcase
         end
         S_UP: begin
            // read the next lower entry while the previous one moves up
            cmd.mem_rd = 1'b1;
            cmd.wr_sel = WR_UP;
            if (st.idx_zero) begin
               state_in = S_UP_TAIL;
            end else begin
               cmd.idx_dec = 1'b1;
            end
         end
         S_UP_TAIL: begin
            cmd.wr_sel = WR_UP;
            state_in   = S_WR_FRONT;
         end
         S_WR_FRONT: begin
            cmd.wr_sel       = WR_FRONT;
            cmd.count_inc    = 1'b1;
            cmd.cursor_front = 1'b1;
            status_in        = ST_OK;
            state_in         = S_FINISH;
         end
         S_SCAN: begin
            if (st.rvalid && st.hit) begin
               if (st.op == OP_FIND) begin
                  cmd.found_set = 1'b1;
                  status_in     = ST_OK;
                  state_in      = S_FINISH;
               end else begin
                  cmd.cursor_del = 1'b1;
                  if (st.prev_last) begin
                     state_in = S_DEL_DONE;
                  end else begin
                     cmd.idx_next_ld = 1'b1;
                     state_in        = S_DOWN;
                  end
               end
            end else if (st.rvalid && st.prev_last) begin
               status_in = (st.op == OP_FIND) ? ST_OK : ST_NOMATCH;
               state_in  = S_FINISH;
            end else begin
               cmd.mem_rd  = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         S_DOWN: begin
            // close the gap: read one entry ahead, write the last one down
            cmd.mem_rd = 1'b1;
            cmd.wr_sel = WR_DOWN;
            if (st.idx_last) begin
               state_in = S_DOWN_TAIL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DOWN_TAIL: begin
            cmd.wr_sel = WR_DOWN;
            state_in   = S_DEL_DONE;
         end
         S_DEL_DONE: begin
            cmd.count_dec = 1'b1;
            status_in     = ST_OK;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tlt_dpath.sv
// ============================================================================
// tlt_dpath - table storage and bookkeeping
// Holds the entry memory, count, read cursor, walk index, the captured
// request and the result register.
// ============================================================================
`default_nettype none

module tlt_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [tlt_pkg::OP_W-1:0] req_op,
   input  tlt_pkg::stamp_type     req_stamp,
   input  tlt_pkg::ctrl_cmd_type  cmd,
   output tlt_pkg::dp_status_type st,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output tlt_pkg::rsp_type       rsp
);
   import tlt_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   stamp_type       mem [DEPTH];
   stamp_type       rdata_ff;
   logic [AW-1:0]   prev_ff;
   logic            rvalid_ff;

   logic [OP_W-1:0] op_ff;
   stamp_type       stamp_ff;
   logic            found_ff, found_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [CW-1:0]   cnt_m1, prev_ext;
   logic            is_full;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   stamp_type       wr_data;

   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   assign cnt_m1   = count_ff - CW'(1);
   assign prev_ext = CW'(prev_ff);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign rd_addr  = cmd.rd_cursor ? cursor_ff[AW-1:0] : idx_ff[AW-1:0];

   // shift writes only fire once a read has landed in rdata_ff
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rdata_ff;
      case (cmd.wr_sel)
         WR_UP: begin
            wr_en   = rvalid_ff;
            wr_addr = prev_ff + AW'(1);
         end
         WR_DOWN: begin
            wr_en   = rvalid_ff;
            wr_addr = prev_ff - AW'(1);
         end
         WR_FRONT: begin
            wr_en   = 1'b1;
            wr_data = stamp_ff;
         end
         WR_END: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[AW-1:0];
            wr_data = stamp_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= mem[rd_addr];
         prev_ff  <= rd_addr;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clr) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = cnt_m1;
      end
   end

   // keep the cursor on the same entry across edits
   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.cursor_clr) begin
         cursor_in = '0;
      end else if (cmd.cursor_inc) begin
         cursor_in = cursor_ff + CW'(1);
      end else if (cmd.cursor_front && (cursor_ff != '0)) begin
         cursor_in = cursor_ff + CW'(1);
      end else if (cmd.cursor_del && (prev_ext < cursor_ff)) begin
         cursor_in = cursor_ff - CW'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_last_ld) begin
         idx_in = cnt_m1;
      end else if (cmd.idx_zero_ld) begin
         idx_in = '0;
      end else if (cmd.idx_next_ld) begin
         idx_in = prev_ext + CW'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - CW'(1);
      end
   end

   always_comb begin
      found_in = found_ff;
      if (cmd.capture) begin
         found_in = 1'b0;
      end else if (cmd.found_set) begin
         found_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = cmd.rsp_status;
         rsp_in.found  = found_ff;
         rsp_in.stamp  = ((op_ff == OP_READ) && (cmd.rsp_status == ST_OK)) ?
                         rdata_ff : '0;
         rsp_in.count  = COUNT_W'(count_ff);
         rsp_in.full   = is_full;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         stamp_ff <= req_stamp;
      end
      idx_ff   <= idx_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rvalid_ff    <= cmd.mem_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      st.op              = op_ff;
      st.full            = is_full;
      st.empty           = (count_ff == '0);
      st.cursor_lt_count = (cursor_ff < count_ff);
      st.rvalid          = rvalid_ff;
      st.hit             = (op_ff == OP_FIND) ? (rdata_ff.hour == stamp_ff.hour) :
                                                (rdata_ff == stamp_ff);
      st.prev_last       = (prev_ext == cnt_m1);
      st.idx_last        = (idx_ff == cnt_m1);
      st.idx_zero        = (idx_ff == '0);
      st.out_free        = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/timestamp_list_table_top.sv
// ============================================================================
// timestamp_list_table_top - ordered time stamp table
// Front/end insert, delete first match, find by hour, cursor read, clear.
// ============================================================================
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    req_type, hour, minute, second
//   rsp_chan   out   valid/ready    status, found, out_hour, out_minute,
//                                   out_second, entry_count, table_full
//
// One request at a time.
// The walks are bound by the single read and single write port of the table.
// Reset clears state, count, cursor, valid flags; table memory is not swept.
// The result register holds while rsp_chan is stalled; the next request is
// accepted while a result still waits.
// ============================================================================
`default_nettype none

module timestamp_list_table_top #(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   tlt_req_if.sink   req_chan,
   tlt_rsp_if.source rsp_chan
);
   import tlt_pkg::*;

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_st;
   rsp_type       rsp;
   stamp_type     req_stamp;

   assign req_stamp.hour   = req_chan.hour;
   assign req_stamp.minute = req_chan.minute;
   assign req_stamp.second = req_chan.second;

   tlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (dp_cmd),
      .st        (dp_st)
   );

   tlt_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_op    (req_chan.req_type),
      .req_stamp (req_stamp),
      .cmd       (dp_cmd),
      .st        (dp_st),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp       (rsp)
   );

   assign rsp_chan.status      = rsp.status;
   assign rsp_chan.found       = rsp.found;
   assign rsp_chan.out_hour    = rsp.stamp.hour;
   assign rsp_chan.out_minute  = rsp.stamp.minute;
   assign rsp_chan.out_second  = rsp.stamp.second;
   assign rsp_chan.entry_count = rsp.count;
   assign rsp_chan.table_full  = rsp.full;

`ifndef ASSERT_OFF
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_FULL)) |-> rsp_chan.table_full)
      else $error("insert dropped while table not full");

   a_zero_stamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != ST_OK)) |->
      ((rsp_chan.out_hour == '0) && (rsp_chan.out_minute == '0) &&
       (rsp_chan.out_second == '0)))
      else $error("stamp reported on failed request");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      dp_st.full |-> ((dp_cmd.wr_sel != WR_END) && (dp_cmd.wr_sel != WR_FRONT)))
      else $error("insert write into full table");
`endif

endmodule

`default_nettype wire
